/* rtl/i2cmbs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, pin action kinds and the command length table that the
// sequencer and its checker share.
// ---------------------------------------------------------------------------
package i2cmbs_pkg;

    // Command codes as they arrive on the input stream.
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RECV  = 3'd3,
        CMD_SACK  = 3'd4,
        CMD_RACK  = 3'd5,
        CMD_IDLE  = 3'd7
    } cmd_t;

    // The one pin action performed on a tick.
    typedef enum logic [1:0] {
        ACT_SCL  = 2'd0,
        ACT_SDA  = 2'd1,
        ACT_READ = 2'd2
    } act_t;

    localparam int PHASE_W = 5;
    localparam int SLOT_W  = 2;

    // Last slot of the three-tick bit pattern.
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

    // Packed widths of the stream payloads.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 16;

    // Index of the last tick of each command.
    function automatic logic [PHASE_W-1:0] cmd_last_phase(input cmd_t cmd);
        logic [PHASE_W-1:0] last;
        unique case (cmd)
            CMD_START: last = 5'd3;
            CMD_STOP:  last = 5'd2;
            CMD_SEND:  last = 5'd24;
            CMD_RECV:  last = 5'd25;
            CMD_SACK:  last = 5'd2;
            CMD_RACK:  last = 5'd3;
            default:   last = 5'd0;
        endcase
        return last;
    endfunction

endpackage

/* rtl/i2c_master_bit_sequencer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Drives SCL and SDA one pin action per timing tick for start, stop, byte
// and acknowledge commands, and reports received data on the last tick.
// ---------------------------------------------------------------------------
// Usage:
// Each transfer on the input stream is one timing tick. tuser carries the
// command request and its code, tdata the byte to send, the ack level to
// drive and the sampled SDA level. Every input transfer produces exactly one
// output transfer with the SCL and SDA levels after that tick, the busy flag,
// the received byte and ack level; tlast marks the last tick of a command.
// A command request is taken only while no command runs; it is dropped
// otherwise, as are unknown codes.
// Output valid follows in the cycle after the input transfer. One tick is
// taken per clock cycle while the output register is free: the sequencer
// state and the output register update together in that cycle. While the
// receiver stalls, the output register holds its transfer and the input is
// not ready; a full output register takes a new tick only while emptied.
// Reset releases both lines high, leaves the sequencer idle and empties the
// output register.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cmbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input ticks.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: tx_byte[7:0], ack_level[8], sda_in[9], zero[15:10]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd_valid[0], func[3:1]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // Output results, tlast is done_res.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: scl_level[0], sda_level[1], busy_res[2], rx_byte[10:3],
    //        ack_seen[11], zero[15:12]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    // Sequencer state.
    cmd_t               cmd_reg, cmd_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [7:0]         tx_reg, tx_next;
    logic [7:0]         rx_reg, rx_next;
    logic               ack_latch_reg, ack_latch_next;
    logic               ack_drive_reg, ack_drive_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;

    // Output register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    // Input field views.
    logic       in_cmd_valid;
    logic [2:0] in_func;
    logic [7:0] in_tx_byte;
    logic       in_ack_level;
    logic       in_sda;
    logic       in_xfer;

    // Working values for the current tick.
    logic               take_cmd;
    cmd_t               cur_cmd;
    logic [PHASE_W-1:0] cur_phase;
    logic [SLOT_W-1:0]  cur_slot;
    logic [7:0]         cur_tx;
    logic [7:0]         cur_rx;
    logic               cur_ack_drive;
    act_t               act_kind;
    logic               act_val;
    logic               is_last;
    logic               slot_step;
    logic [7:0]         rx_rep;
    logic               ack_rep;
    logic               busy;

    assign in_tx_byte   = s_axis_tdata[7:0];
    assign in_ack_level = s_axis_tdata[8];
    assign in_sda       = s_axis_tdata[9];
    assign in_cmd_valid = s_axis_tuser[0];
    assign in_func      = s_axis_tuser[3:1];

    // The input is taken whenever the output register is free this cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // A new command starts on this tick when idle and the code is known.
    always_comb
    begin
        take_cmd      = (cmd_reg == CMD_IDLE) && in_cmd_valid && (in_func <= CMD_RACK);
        cur_cmd       = take_cmd ? cmd_t'(in_func) : cmd_reg;
        cur_phase     = take_cmd ? '0 : phase_reg;
        cur_slot      = take_cmd ? '0 : slot_reg;
        cur_tx        = take_cmd ? in_tx_byte : tx_reg;
        cur_rx        = take_cmd ? 8'd0 : rx_reg;
        cur_ack_drive = take_cmd ? in_ack_level : ack_drive_reg;
    end

    // Pin action decode for the current command and phase.
    always_comb
    begin
        act_kind = ACT_SCL;
        act_val  = 1'b0;
        unique case (cur_cmd)
            CMD_START:
            begin
                act_kind = cur_phase[0] ? ACT_SCL : ACT_SDA;
                act_val  = !cur_phase[1];
            end
            CMD_STOP:
            begin
                act_kind = (cur_phase == 5'd1) ? ACT_SCL : ACT_SDA;
                act_val  = (cur_phase != 5'd0);
            end
            CMD_SEND:
            begin
                if (cur_phase != 5'd0)
                begin
                    if (cur_slot == 2'd0)
                    begin
                        act_kind = ACT_SDA;
                        act_val  = cur_tx[7];
                    end
                    else
                    begin
                        act_val = (cur_slot == 2'd1);
                    end
                end
            end
            CMD_RECV:
            begin
                if (cur_phase == 5'd1)
                begin
                    act_kind = ACT_SDA;
                    act_val  = 1'b1;
                end
                else if (cur_phase != 5'd0)
                begin
                    if (cur_slot == 2'd0)
                    begin
                        act_val = 1'b1;
                    end
                    else if (cur_slot == 2'd1)
                    begin
                        act_kind = ACT_READ;
                    end
                end
            end
            CMD_SACK:
            begin
                if (cur_phase == 5'd0)
                begin
                    act_kind = ACT_SDA;
                    act_val  = cur_ack_drive;
                end
                else
                begin
                    act_val = (cur_phase == 5'd1);
                end
            end
            CMD_RACK:
            begin
                unique case (cur_phase[1:0])
                    2'd0:
                    begin
                        act_kind = ACT_SDA;
                        act_val  = 1'b1;
                    end
                    2'd1:
                    begin
                        act_val = 1'b1;
                    end
                    2'd2:
                    begin
                        act_kind = ACT_READ;
                    end
                    default:
                    begin
                        act_val = 1'b0;
                    end
                endcase
            end
            default:
            begin
                act_kind = ACT_SCL;
                act_val  = 1'b0;
            end
        endcase
    end

    // State update and result for this tick.
    always_comb
    begin
        cmd_next       = cur_cmd;
        phase_next     = cur_phase;
        slot_next      = cur_slot;
        tx_next        = cur_tx;
        rx_next        = cur_rx;
        ack_latch_next = ack_latch_reg;
        ack_drive_next = cur_ack_drive;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        is_last        = 1'b0;
        slot_step      = 1'b0;
        rx_rep         = 8'd0;
        ack_rep        = 1'b1;
        busy           = 1'b0;

        if (cur_cmd != CMD_IDLE)
        begin
            // Apply the pin action.
            case (act_kind)
                ACT_SCL:
                begin
                    scl_next = act_val;
                end
                ACT_SDA:
                begin
                    sda_next = act_val;
                    if (cur_cmd == CMD_SEND)
                    begin
                        tx_next = {cur_tx[6:0], 1'b0};
                    end
                end
                default:
                begin
                    if (cur_cmd == CMD_RECV)
                    begin
                        rx_next = {cur_rx[6:0], in_sda};
                    end
                    else
                    begin
                        ack_latch_next = in_sda;
                    end
                end
            endcase

            // Step the three-tick bit pattern inside the byte commands.
            slot_step = ((cur_cmd == CMD_SEND) && (cur_phase != 5'd0))
                     || ((cur_cmd == CMD_RECV) && (cur_phase > 5'd1));
            if (slot_step)
            begin
                slot_next = (cur_slot == SLOT_LAST) ? '0 : cur_slot + 2'd1;
            end

            // Finish or advance the command.
            is_last = (cur_phase >= cmd_last_phase(cur_cmd));
            if (is_last)
            begin
                if (cur_cmd == CMD_RECV)
                begin
                    rx_rep = rx_next;
                end
                if (cur_cmd == CMD_RACK)
                begin
                    ack_rep = ack_latch_next;
                end
                cmd_next   = CMD_IDLE;
                phase_next = '0;
            end
            else
            begin
                phase_next = cur_phase + 5'd1;
                busy       = 1'b1;
            end
        end

        out_data_next = {4'd0, ack_rep, rx_rep, busy, sda_next, scl_next};
        out_last_next = is_last;
    end

    // Sequencer registers advance once per input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_IDLE;
            phase_reg     <= '0;
            slot_reg      <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            ack_latch_reg <= 1'b1;
            ack_drive_reg <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (in_xfer)
        begin
            cmd_reg       <= cmd_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            tx_reg        <= tx_next;
            rx_reg        <= rx_next;
            ack_latch_reg <= ack_latch_next;
            ack_drive_reg <= ack_drive_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with each tick's result.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/i2cmbs_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer checker
// Port-level assertions on the sequencer's streams, bound to the top level.
// ---------------------------------------------------------------------------
module i2cmbs_checker
    import i2cmbs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // A pending result stays offered while the receiver stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output transfer was dropped or changed.");

    // An empty output register never blocks the input.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input not ready while the output register is empty.");

    // The last tick of a command leaves the sequencer idle.
    a_last_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
        else $error("Busy reported on the last tick of a command.");

    // Received byte and ack level show their idle values except on a last tick.
    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[10:3] == 8'd0) && m_axis_tdata[11])
        else $error("Receive report outside the last tick of a command.");

    // Every input transfer yields a result in the following cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("Accepted tick produced no result.");

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_i2cmbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
